@@ src/mfp_pkg.sv @@
// Shared types and constants of the management frame receive parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mfp_pkg;

	localparam int POS_W           = 12;
	localparam int MAX_FRAME_LEN_D = 2048;
	localparam int MAC_W           = 48;
	localparam int AID_W           = 14;
	localparam int MIN_HDR_LEN     = 24;
	localparam int FIXED_END       = 30;
	localparam int ELEM_START      = 24 + 12;
	localparam int POS_CLAMP       = 4095;
	localparam int TDATA_OUT_W     = 56;

	localparam logic [15:0] BI_DEFAULT  = 16'd100;
	localparam logic [15:0] AUTH_SEQ_OK = 16'd2;
	localparam logic [7:0]  EID_TIM     = 8'd5;
	localparam logic [7:0]  TIM_MIN_LEN = 8'd2;

	localparam logic [3:0] ST_BEACON     = 4'h8;
	localparam logic [3:0] ST_AUTH       = 4'hB;
	localparam logic [3:0] ST_ASSOC_RESP = 4'h1;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_OWN_MAC      = 1'b0,
		CFG_TARGET_BSSID = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE       = 2'd0,
		KIND_BEACON     = 2'd1,
		KIND_AUTH       = 2'd2,
		KIND_ASSOC_RESP = 2'd3
	} frame_kind_t;

	typedef struct packed {
		logic [POS_W-1:0] total;
		logic [3:0]       subtype;
		logic [2:0]       addr_match;
		logic [15:0]      fixed_a;
		logic [15:0]      fixed_b;
		logic [15:0]      bi_cand;
		logic             tim_ok;
		logic [7:0]       tim_count;
		logic [7:0]       tim_period;
	} frame_sum_t;

	typedef struct packed {
		frame_kind_t      kind;
		logic             auth_ok;
		logic             assoc_ok;
		logic [AID_W-1:0] station_aid;
		logic             beacon_seen;
		logic [7:0]       dtim_cnt;
		logic [7:0]       dtim_intv;
		logic [15:0]      beacon_interval;
	} result_t;

endpackage

`default_nettype wire

@@ src/wifi_mgmt_frame_rx_parser.sv @@
// Top level of the 802.11 management frame receive parser: input register,
// configuration registers, result register. Depends on mfp_pkg, mfp_frame_track, mfp_session.
//
// The parser takes one frame byte per cycle on the s_ stream while s_tready is high and
// gives one status item on the m_ stream for every byte marked tlast; m_tvalid rises
// when that byte leaves the input register and is committed, which waits while the
// previous status item is unread; a clear item (tuser = 1) gives none. Every byte passes
// through one input register and is then folded into the frame state, so the sustained
// rate is one item per clock while no stall holds it. The input side stalls only when
// a final byte waits in the input register while the previous status item is still
// unread. Configuration writes are always taken and must be made while no frame is in flight.
`default_nettype none

module wifi_mgmt_frame_rx_parser #(
	parameter int MAX_FRAME_LEN = mfp_pkg::MAX_FRAME_LEN_D
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,  // data_byte[7:0]
	input  wire logic                            s_tlast,  // last_byte
	input  wire logic                            s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// frame_kind[1:0], auth_ok[2], assoc_ok[3], station_aid[17:4], beacon_seen[18],
	// dtim_cnt[26:19], dtim_intv[34:27], beacon_interval[50:35], zero[55:51]
	output logic [mfp_pkg::TDATA_OUT_W-1:0]      m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic                            cfg_index,
	input  wire logic [mfp_pkg::MAC_W-1:0]       cfg_data
);

	logic                      valid_s1;
	mfp_pkg::opcode_t          op_s1;
	logic [7:0]                data_s1;
	logic                      last_s1;
	logic                      stall_s1;
	logic                      adv_s1;
	logic                      byte_en;
	logic                      clear_en;
	logic                      commit_en;
	logic [mfp_pkg::MAC_W-1:0] own_mac_q;
	logic [mfp_pkg::MAC_W-1:0] bssid_q;
	logic                      m_valid_q;
	mfp_pkg::result_t          result;
	mfp_pkg::result_t          res_q;
	mfp_pkg::frame_sum_t       sum;

	assign stall_s1  = valid_s1 && (op_s1 == mfp_pkg::OP_BYTE) && last_s1 && m_valid_q && !m_tready;
	assign adv_s1    = valid_s1 && !stall_s1;
	assign s_tready  = !stall_s1;
	assign byte_en   = adv_s1 && (op_s1 == mfp_pkg::OP_BYTE);
	assign clear_en  = adv_s1 && (op_s1 == mfp_pkg::OP_CLEAR);
	assign commit_en = byte_en && last_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= mfp_pkg::opcode_t'(s_tuser);
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			bssid_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mfp_pkg::cfg_index_t'(cfg_index))
				mfp_pkg::CFG_OWN_MAC:      own_mac_q <= cfg_data;
				mfp_pkg::CFG_TARGET_BSSID: bssid_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	mfp_frame_track #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (byte_en),
		.restart     (clear_en || commit_en),
		.data_byte   (data_s1),
		.own_mac     (own_mac_q),
		.target_bssid(bssid_q),
		.sum         (sum)
	);

	mfp_session u_session (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit_en   (commit_en),
		.clear_en    (clear_en),
		.target_bssid(bssid_q),
		.sum         (sum),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit_en) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en)
			res_q <= result;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, res_q.beacon_interval, res_q.dtim_intv, res_q.dtim_cnt,
	                   res_q.beacon_seen, res_q.station_aid, res_q.assoc_ok, res_q.auth_ok,
	                   res_q.kind};

endmodule

`default_nettype wire

@@ src/mfp_frame_track.sv @@
// Per-frame byte capture: position, subtype, address filter, fixed fields, element walk.
// Depends on mfp_pkg.
`default_nettype none

module mfp_frame_track #(
	parameter int MAX_FRAME_LEN = mfp_pkg::MAX_FRAME_LEN_D
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      byte_en,
	input  wire logic                      restart,
	input  wire logic [7:0]                data_byte,
	input  wire logic [mfp_pkg::MAC_W-1:0] own_mac,
	input  wire logic [mfp_pkg::MAC_W-1:0] target_bssid,
	output mfp_pkg::frame_sum_t            sum
);

	logic [mfp_pkg::POS_W-1:0] pos_q, pos_n;
	logic [3:0]                sub_q, sub_n;
	logic [2:0]                match_q, match_n;
	logic [31:0]               fixed_q, fixed_n;
	logic [15:0]               bi_q, bi_n;
	logic [mfp_pkg::POS_W-1:0] nes_q, nes_n;
	logic [7:0]                eid_q, eid_n;
	logic [7:0]                elen_q, elen_n;
	logic                      tim_q, tim_n;
	logic [7:0]                tcnt_q, tcnt_n;
	logic [7:0]                tper_q, tper_n;

	always_comb begin
		logic [mfp_pkg::POS_W-1:0] p;
		logic [mfp_pkg::POS_W:0]   p13;
		logic [mfp_pkg::POS_W:0]   nes13;
		logic [mfp_pkg::POS_W:0]   nx;
		logic [2:0]                aidx;
		logic [1:0]                fidx;
		logic [13:0]               tim_end;

		pos_n   = pos_q;
		sub_n   = sub_q;
		match_n = match_q;
		fixed_n = fixed_q;
		bi_n    = bi_q;
		nes_n   = nes_q;
		eid_n   = eid_q;
		elen_n  = elen_q;
		tim_n   = tim_q;
		tcnt_n  = tcnt_q;
		tper_n  = tper_q;
		p       = pos_q;
		p13     = {1'b0, pos_q};
		nes13   = {1'b0, nes_q};
		nx      = nes13 + 13'd2 + {5'b0, data_byte};
		aidx    = 3'(p - 12'd4);
		fidx    = 2'(p - 12'd26);

		if (byte_en && (pos_q < mfp_pkg::POS_W'(MAX_FRAME_LEN))) begin
			pos_n = pos_q + 12'd1;
			if (p == 12'd0) begin
				sub_n = sub_q | data_byte[7:4];
			end else if (p >= 12'd4 && p < 12'd10) begin
				if (data_byte != own_mac[{aidx, 3'b000} +: 8])
					match_n[0] = 1'b0;
			end else if (p >= 12'd10 && p < 12'd16) begin
				aidx = 3'(p - 12'd10);
				if (data_byte != target_bssid[{aidx, 3'b000} +: 8])
					match_n[1] = 1'b0;
			end else if (p >= 12'd16 && p < 12'd22) begin
				aidx = 3'(p - 12'd16);
				if (data_byte != target_bssid[{aidx, 3'b000} +: 8])
					match_n[2] = 1'b0;
			end else if (p >= 12'd26 && p < 12'd30) begin
				fixed_n[{fidx, 3'b000} +: 8] = fixed_q[{fidx, 3'b000} +: 8] | data_byte;
			end else if (p == 12'd32) begin
				bi_n[7:0] = bi_q[7:0] | data_byte;
			end else if (p == 12'd33) begin
				bi_n[15:8] = bi_q[15:8] | data_byte;
			end

			if (p >= mfp_pkg::POS_W'(mfp_pkg::ELEM_START)) begin
				if (tim_q) begin
					if (p13 == nes13 + 13'd2)
						tcnt_n = data_byte;
					else if (p13 == nes13 + 13'd3)
						tper_n = data_byte;
				end else if (p == nes_q) begin
					eid_n = data_byte;
				end else if (p13 == nes13 + 13'd1) begin
					elen_n = data_byte;
					if (eid_q == mfp_pkg::EID_TIM && data_byte >= mfp_pkg::TIM_MIN_LEN)
						tim_n = 1'b1;
					else if (nx > 13'(mfp_pkg::POS_CLAMP))
						nes_n = mfp_pkg::POS_W'(mfp_pkg::POS_CLAMP);
					else
						nes_n = nx[mfp_pkg::POS_W-1:0];
				end
			end
		end

		tim_end            = {2'b0, nes_n} + 14'd2 + {6'b0, elen_n};
		sum.total          = pos_n;
		sum.subtype        = sub_n;
		sum.addr_match     = match_n;
		sum.fixed_a        = fixed_n[15:0];
		sum.fixed_b        = fixed_n[31:16];
		sum.bi_cand        = bi_n;
		sum.tim_ok         = tim_n && ({2'b0, pos_n} >= tim_end);
		sum.tim_count      = tcnt_n;
		sum.tim_period     = tper_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sub_q   <= '0;
			match_q <= 3'b111;
			fixed_q <= '0;
			bi_q    <= '0;
			nes_q   <= mfp_pkg::POS_W'(mfp_pkg::ELEM_START);
			eid_q   <= '0;
			elen_q  <= '0;
			tim_q   <= 1'b0;
			tcnt_q  <= '0;
			tper_q  <= '0;
		end else if (restart) begin
			pos_q   <= '0;
			sub_q   <= '0;
			match_q <= 3'b111;
			fixed_q <= '0;
			bi_q    <= '0;
			nes_q   <= mfp_pkg::POS_W'(mfp_pkg::ELEM_START);
			eid_q   <= '0;
			elen_q  <= '0;
			tim_q   <= 1'b0;
			tcnt_q  <= '0;
			tper_q  <= '0;
		end else begin
			pos_q   <= pos_n;
			sub_q   <= sub_n;
			match_q <= match_n;
			fixed_q <= fixed_n;
			bi_q    <= bi_n;
			nes_q   <= nes_n;
			eid_q   <= eid_n;
			elen_q  <= elen_n;
			tim_q   <= tim_n;
			tcnt_q  <= tcnt_n;
			tper_q  <= tper_n;
		end
	end

endmodule

`default_nettype wire

@@ src/mfp_session.sv @@
// Session state and end-of-frame commit: auth, association, beacon sync.
// Depends on mfp_pkg; fed by mfp_frame_track.
`default_nettype none

module mfp_session (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      commit_en,
	input  wire logic                      clear_en,
	input  wire logic [mfp_pkg::MAC_W-1:0] target_bssid,
	input  mfp_pkg::frame_sum_t            sum,
	output mfp_pkg::result_t               result
);

	logic                      auth_q, auth_n;
	logic                      assoc_q, assoc_n;
	logic [mfp_pkg::AID_W-1:0] aid_q, aid_n;
	logic                      seen_q, seen_n;
	logic [7:0]                cnt_q, cnt_n;
	logic [7:0]                per_q, per_n;
	logic [15:0]               bi_q, bi_n;
	mfp_pkg::frame_kind_t      kind;

	always_comb begin
		logic [mfp_pkg::AID_W-1:0] aid_raw;

		auth_n  = auth_q;
		assoc_n = assoc_q;
		aid_n   = aid_q;
		seen_n  = seen_q;
		cnt_n   = cnt_q;
		per_n   = per_q;
		bi_n    = bi_q;
		kind    = mfp_pkg::KIND_NONE;
		aid_raw = sum.fixed_b[mfp_pkg::AID_W-1:0];

		if (sum.total >= mfp_pkg::POS_W'(mfp_pkg::MIN_HDR_LEN) && target_bssid != '0) begin
			if (sum.subtype == mfp_pkg::ST_BEACON) begin
				if (sum.addr_match[2]) begin
					kind = mfp_pkg::KIND_BEACON;
					if (sum.total >= mfp_pkg::POS_W'(mfp_pkg::ELEM_START)) begin
						bi_n = (sum.bi_cand != '0) ? sum.bi_cand : mfp_pkg::BI_DEFAULT;
						if (sum.tim_ok) begin
							cnt_n  = sum.tim_count;
							seen_n = 1'b1;
							if (sum.tim_period != '0)
								per_n = sum.tim_period;
						end
					end
				end
			end else if (sum.addr_match[0] && (sum.addr_match[1] || sum.addr_match[2])) begin
				if (sum.subtype == mfp_pkg::ST_AUTH) begin
					kind = mfp_pkg::KIND_AUTH;
					if (sum.total >= mfp_pkg::POS_W'(mfp_pkg::FIXED_END) &&
					    sum.fixed_a == mfp_pkg::AUTH_SEQ_OK && sum.fixed_b == '0)
						auth_n = 1'b1;
				end else if (sum.subtype == mfp_pkg::ST_ASSOC_RESP) begin
					kind = mfp_pkg::KIND_ASSOC_RESP;
					if (sum.total >= mfp_pkg::POS_W'(mfp_pkg::FIXED_END) && sum.fixed_a == '0) begin
						aid_n   = (aid_raw == '0) ? mfp_pkg::AID_W'(1) : aid_raw;
						assoc_n = 1'b1;
					end
				end
			end
		end

		result.kind            = kind;
		result.auth_ok         = auth_n;
		result.assoc_ok        = assoc_n;
		result.station_aid     = aid_n;
		result.beacon_seen     = seen_n;
		result.dtim_cnt        = cnt_n;
		result.dtim_intv       = per_n;
		result.beacon_interval = bi_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_q  <= 1'b0;
			assoc_q <= 1'b0;
			aid_q   <= '0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
			per_q   <= '0;
			bi_q    <= mfp_pkg::BI_DEFAULT;
		end else if (clear_en) begin
			auth_q  <= 1'b0;
			assoc_q <= 1'b0;
			aid_q   <= '0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
			per_q   <= '0;
		end else if (commit_en) begin
			auth_q  <= auth_n;
			assoc_q <= assoc_n;
			aid_q   <= aid_n;
			seen_q  <= seen_n;
			cnt_q   <= cnt_n;
			per_q   <= per_n;
			bi_q    <= bi_n;
		end
	end

endmodule

`default_nettype wire

@@ src/mfp_checker.sv @@
// Port-level checks for the management frame receive parser, bound to its top level.
// Depends on mfp_pkg and wifi_mgmt_frame_rx_parser.
`default_nettype none

module mfp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       s_tlast,
	input wire logic                       s_tuser,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [mfp_pkg::TDATA_OUT_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status item changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no status item pending");

	a_status_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast &&
		                          (s_tuser == mfp_pkg::OP_BYTE), 2))
		else $error("status item without a final frame byte");

	a_aid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[17:4] != '0)
		else $error("association reported with zero id");

	a_interval_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[50:35] != '0)
		else $error("beacon interval reported as zero");

endmodule

bind wifi_mgmt_frame_rx_parser mfp_checker u_mfp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
